// ===== rtl/core/i2c_master_write_sequencer_defines.svh =====
// Assertion macros used by the I2C write sequencer control module.
`ifndef I2C_MASTER_WRITE_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_WRITE_SEQUENCER_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define SEQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Checks that a condition in one cycle leads to a consequence in the next.
`define SEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/i2cmws_pkg.sv =====
// Types, codes and sizes shared by the I2C write sequencer modules.
`timescale 1ns / 1ps

package i2cmws_pkg;

	// Payload buffer size and its address width.
	localparam int BUF_DEPTH = 128;
	localparam int BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

	// Retry limit after reset.
	localparam logic [15:0] RETRY_RESET = 16'd400;

	// Operation codes.
	localparam logic [2:0] OP_POLL         = 3'd0;
	localparam logic [2:0] OP_LOAD         = 3'd1;
	localparam logic [2:0] OP_SUBMIT_WRITE = 3'd2;
	localparam logic [2:0] OP_SUBMIT_PROBE = 3'd3;
	localparam logic [2:0] OP_ABORT        = 3'd4;

	// Sequencer phases.
	localparam logic [3:0] PH_IDLE      = 4'd0;
	localparam logic [3:0] PH_WAIT_BUSY = 4'd1;
	localparam logic [3:0] PH_START     = 4'd2;
	localparam logic [3:0] PH_WAIT_SB   = 4'd3;
	localparam logic [3:0] PH_ADDR      = 4'd4;
	localparam logic [3:0] PH_WAIT_ADDR = 4'd5;
	localparam logic [3:0] PH_TX        = 4'd6;
	localparam logic [3:0] PH_WAIT_TXE  = 4'd7;
	localparam logic [3:0] PH_STOP      = 4'd8;
	localparam logic [3:0] PH_WAIT_BTF  = 4'd9;
	localparam logic [3:0] PH_FINISH    = 4'd10;

	// Result codes.
	localparam logic [1:0] RES_IDLE = 2'd0;
	localparam logic [1:0] RES_BUSY = 2'd1;
	localparam logic [1:0] RES_OK   = 2'd2;
	localparam logic [1:0] RES_ERR  = 2'd3;

	// One input item.
	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] target_address;
		logic [7:0] length;
		logic [6:0] byte_index;
		logic [7:0] data_byte;
		logic       bus_busy;
		logic       start_sent;
		logic       address_done;
		logic       tx_empty;
		logic       transfer_finished;
		logic       ack_failure;
	} item_t;

	// One result item.
	typedef struct packed {
		logic        accepted;
		logic        data_write_valid;
		logic [7:0]  data_out;
		logic        issue_start;
		logic        issue_stop;
		logic        clear_ack_failure;
		logic        request_recovery;
		logic        done_res;
		logic [1:0]  result_code;
		logic        is_idle;
		logic [15:0] error_count;
	} res_t;

	// Result of one step before the buffer data is merged in.
	typedef struct packed {
		res_t res;
		logic use_mem;
	} step_t;

endpackage

// ===== rtl/core/i2cmws_buf.sv =====
// Payload byte buffer: one write port and one registered read port.
`timescale 1ns / 1ps

module i2cmws_buf
	import i2cmws_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [BUF_AW-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic              re,
	input  logic [BUF_AW-1:0] raddr,
	output logic [7:0]        rdata
);

	logic [7:0] mem_q [BUF_DEPTH];
	logic [7:0] rdata_q;

	// Byte loads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/i2cmws_ctrl.sv =====
// Sequencer control: phase, retry and error state, and the per-item step logic.
`timescale 1ns / 1ps

`include "i2c_master_write_sequencer_defines.svh"

module i2cmws_ctrl
	import i2cmws_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  item_t             item,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_data,
	output step_t             step,
	output logic              buf_we,
	output logic [BUF_AW-1:0] buf_waddr,
	output logic              buf_re,
	output logic [BUF_AW-1:0] buf_raddr
);

	logic [15:0] retry_limit_q;
	logic [3:0]  phase_q, phase_n;
	logic [7:0]  address_reg_q, address_reg_n;
	logic [7:0]  send_length_q, send_length_n;
	logic [7:0]  send_position_q, send_position_n;
	logic        probe_mode_q, probe_mode_n;
	logic [15:0] retry_count_q, retry_count_n;
	logic [1:0]  last_result_q, last_result_n;
	logic [15:0] fail_total_q, fail_total_n;

	logic [16:0] retry_inc;
	logic        overrun;
	logic        do_fail;
	logic        do_ok;
	logic        wait_flag;
	logic        pos_in_buf;
	logic [7:0]  load_index;
	logic        len_ok;
	logic        submit_take;

	// Shared terms of the step.
	assign retry_inc  = {1'b0, retry_count_q} + 17'd1;
	assign overrun    = retry_inc > {1'b0, retry_limit_q};
	assign pos_in_buf = send_position_q < 8'(BUF_DEPTH);
	assign load_index = {1'b0, item.byte_index};
	assign len_ok     = (item.length != 8'd0) && (item.length <= 8'(BUF_DEPTH));

	// Flag that a wait phase is waiting on.
	always_comb begin
		case (phase_q)
			PH_WAIT_SB:   wait_flag = item.start_sent;
			PH_WAIT_ADDR: wait_flag = item.address_done;
			PH_WAIT_TXE:  wait_flag = item.tx_empty;
			PH_WAIT_BTF:  wait_flag = item.transfer_finished;
			default:      wait_flag = 1'b0;
		endcase
	end

	// Next state and result of one item.
	always_comb begin
		phase_n         = phase_q;
		address_reg_n   = address_reg_q;
		send_length_n   = send_length_q;
		send_position_n = send_position_q;
		probe_mode_n    = probe_mode_q;
		retry_count_n   = retry_count_q;
		last_result_n   = last_result_q;
		fail_total_n    = fail_total_q;
		step            = '0;
		do_fail         = 1'b0;
		do_ok           = 1'b0;

		case (item.opcode)
			OP_LOAD: begin
				// Buffer writes are handled on the memory port.
			end
			OP_SUBMIT_WRITE, OP_SUBMIT_PROBE: begin
				if (phase_q == PH_IDLE &&
				    (item.opcode == OP_SUBMIT_PROBE || len_ok)) begin
					step.res.accepted          = 1'b1;
					step.res.clear_ack_failure = item.ack_failure;
					address_reg_n   = item.target_address;
					send_length_n   = (item.opcode == OP_SUBMIT_PROBE) ? 8'd0 : item.length;
					send_position_n = 8'd0;
					probe_mode_n    = item.opcode == OP_SUBMIT_PROBE;
					retry_count_n   = 16'd0;
					last_result_n   = RES_BUSY;
					phase_n         = PH_WAIT_BUSY;
				end
			end
			OP_ABORT: begin
				do_fail = phase_q != PH_IDLE;
			end
			OP_POLL: begin
				case (phase_q)
					PH_IDLE: begin
					end
					PH_WAIT_BUSY: begin
						if (item.bus_busy) begin
							if (overrun) begin
								do_fail = 1'b1;
							end else begin
								retry_count_n = retry_inc[15:0];
							end
						end else begin
							retry_count_n = 16'd0;
							phase_n       = PH_START;
						end
					end
					PH_START: begin
						step.res.issue_start = 1'b1;
						phase_n              = PH_WAIT_SB;
					end
					PH_ADDR: begin
						step.res.data_write_valid = 1'b1;
						step.res.data_out         = address_reg_q;
						phase_n                   = PH_WAIT_ADDR;
					end
					PH_TX: begin
						// The byte itself comes from the buffer's registered read port.
						step.res.data_write_valid = 1'b1;
						step.use_mem              = pos_in_buf;
						send_position_n           = send_position_q + 8'd1;
						phase_n                   = PH_WAIT_TXE;
					end
					PH_STOP: begin
						phase_n = PH_WAIT_BTF;
					end
					PH_WAIT_SB, PH_WAIT_ADDR, PH_WAIT_TXE, PH_WAIT_BTF: begin
						// A set flag wins over an ack failure.
						if (wait_flag) begin
							case (phase_q)
								PH_WAIT_SB: begin
									retry_count_n = 16'd0;
									phase_n       = PH_ADDR;
								end
								PH_WAIT_ADDR: begin
									retry_count_n = 16'd0;
									if (probe_mode_q || send_length_q == 8'd0) begin
										step.res.issue_stop = 1'b1;
										phase_n             = PH_FINISH;
									end else begin
										phase_n = PH_TX;
									end
								end
								PH_WAIT_TXE: begin
									retry_count_n = 16'd0;
									phase_n = (send_position_q < send_length_q) ? PH_TX : PH_STOP;
								end
								default: begin
									step.res.issue_stop = 1'b1;
									phase_n             = PH_FINISH;
								end
							endcase
						end else if (item.ack_failure || overrun) begin
							do_fail = 1'b1;
						end else begin
							retry_count_n = retry_inc[15:0];
						end
					end
					PH_FINISH: begin
						do_ok = 1'b1;
					end
					default: begin
						do_fail = 1'b1;
					end
				endcase
			end
			default: begin
				// Unused opcodes do nothing.
			end
		endcase

		// Failure ends the transaction with STOP and a recovery request.
		if (do_fail) begin
			step.res.issue_stop        = 1'b1;
			step.res.clear_ack_failure = item.ack_failure;
			step.res.request_recovery  = 1'b1;
			step.res.done_res          = 1'b1;
			phase_n                    = PH_IDLE;
			last_result_n              = RES_ERR;
			if (fail_total_q != 16'hFFFF) begin
				fail_total_n = fail_total_q + 16'd1;
			end
		end

		if (do_ok) begin
			step.res.done_res = 1'b1;
			phase_n           = PH_IDLE;
			last_result_n     = RES_OK;
		end

		// Status after the step.
		step.res.result_code = last_result_n;
		step.res.is_idle     = phase_n == PH_IDLE;
		step.res.error_count = fail_total_n;
	end

	// Buffer port requests for this item.
	assign buf_we    = take && item.opcode == OP_LOAD && phase_q == PH_IDLE &&
	                   load_index < 8'(BUF_DEPTH);
	assign buf_waddr = load_index[BUF_AW-1:0];
	assign buf_re    = take && step.use_mem;
	assign buf_raddr = send_position_q[BUF_AW-1:0];

	// An accepted submit taken this cycle.
	assign submit_take = take && step.res.accepted;

	// Retry limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= RETRY_RESET;
		end else if (cfg_we) begin
			retry_limit_q <= cfg_data;
		end
	end

	// Sequencer state, updated once per accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			address_reg_q   <= 8'd0;
			send_length_q   <= 8'd0;
			send_position_q <= 8'd0;
			probe_mode_q    <= 1'b0;
			retry_count_q   <= 16'd0;
			last_result_q   <= RES_IDLE;
			fail_total_q    <= 16'd0;
		end else if (take) begin
			phase_q         <= phase_n;
			address_reg_q   <= address_reg_n;
			send_length_q   <= send_length_n;
			send_position_q <= send_position_n;
			probe_mode_q    <= probe_mode_n;
			retry_count_q   <= retry_count_n;
			last_result_q   <= last_result_n;
			fail_total_q    <= fail_total_n;
		end
	end

	`SEQ_ASSERT(a_phase_legal, phase_q <= PH_FINISH, "sequencer phase out of range")
	`SEQ_ASSERT_NEXT(a_submit_starts, submit_take, phase_q == PH_WAIT_BUSY, "submit ignored")
	`SEQ_ASSERT(a_done_idle, step.res.done_res |-> step.res.is_idle, "done while not idle")
	`SEQ_ASSERT(a_err_monotonic, fail_total_q >= $past(fail_total_q), "error count fell")

endmodule

// ===== rtl/core/i2cmws_outq.sv =====
// Result pipeline: merges buffer data into the result and holds it for the consumer.
`timescale 1ns / 1ps

module i2cmws_outq
	import i2cmws_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  step_t      step,
	input  logic [7:0] rdata,
	output logic       item_stall,
	output logic       res_valid,
	input  logic       res_stall,
	output res_t       res
);

	logic  valid_s1;
	step_t step_s1;
	logic  out_valid_q;
	res_t  out_q;
	logic  out_free;
	logic  move_s1;
	res_t  merged_s1;

	// The output register frees up when empty or being taken.
	assign out_free   = !out_valid_q || !res_stall;
	assign move_s1    = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;

	// Buffer data arrives alongside the stage one item.
	always_comb begin
		merged_s1 = step_s1.res;
		if (step_s1.use_mem) begin
			merged_s1.data_out = rdata;
		end
	end

	// Stage one valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage one payload.
	always_ff @(posedge clk) begin
		if (take) begin
			step_s1 <= step;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_s1) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (move_s1) begin
			out_q <= merged_s1;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

// ===== rtl/core/i2c_master_write_sequencer.sv =====
// I2C master write and address-probe sequencer (top level).
// Takes one item per clock cycle while item_stall is low. Each item produces exactly one
// result item, which passes through a stage that waits on the payload buffer's registered
// read, and is then held in an output register until taken; while a result waits
// in the output register, one further item is still taken. The single buffer read port
// is used only by a poll in the data-byte phase. The retry limit register is written on
// the cfg channel, which is always ready, and must only be written while the sequencer
// is idle.
`timescale 1ns / 1ps

module i2c_master_write_sequencer
	import i2cmws_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	output logic        res_valid,
	input  logic        res_stall,
	output res_t        res,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic              take;
	step_t             step;
	logic              buf_we;
	logic [BUF_AW-1:0] buf_waddr;
	logic              buf_re;
	logic [BUF_AW-1:0] buf_raddr;
	logic [7:0]        buf_rdata;

	assign take      = item_valid && !item_stall;
	assign cfg_ready = 1'b1;

	// Phase sequencing and status state.
	i2cmws_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.item      (item),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.step      (step),
		.buf_we    (buf_we),
		.buf_waddr (buf_waddr),
		.buf_re    (buf_re),
		.buf_raddr (buf_raddr)
	);

	// Payload bytes.
	i2cmws_buf u_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (buf_waddr),
		.wdata (item.data_byte),
		.re    (buf_re),
		.raddr (buf_raddr),
		.rdata (buf_rdata)
	);

	// Result staging toward the consumer.
	i2cmws_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.step       (step),
		.rdata      (buf_rdata),
		.item_stall (item_stall),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res)
	);

endmodule

// ===== tb/tb_i2c_master_write_sequencer.sv =====
// Self-checking testbench for the I2C master write and probe sequencer.
`timescale 1ns / 1ps

module tb_i2c_master_write_sequencer;
	import i2cmws_pkg::*;

	// Opcodes the block treats as no operation.
	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

	// Status flag positions for directed items: {busy, sb, addr, txe, btf, ack}.
	localparam logic [5:0] F_NONE = 6'b000000;
	localparam logic [5:0] F_BUSY = 6'b100000;
	localparam logic [5:0] F_SB   = 6'b010000;
	localparam logic [5:0] F_ADDR = 6'b001000;
	localparam logic [5:0] F_ACK  = 6'b000001;
	localparam logic [5:0] F_ALL  = 6'b111111;

	localparam int ITEMS_PER_SETTING = 280;
	localparam int QUIET_LIMIT       = 2000;
	localparam int REPORT_LINES      = 40;

	// Architectural state of the sequencer, without the payload buffer.
	typedef struct packed {
		logic [3:0]  phase;
		logic [7:0]  address;
		logic [7:0]  send_len;
		logic [7:0]  send_pos;
		logic        probe;
		logic [15:0] retries;
		logic [15:0] limit;
		logic [1:0]  last;
		logic [15:0] fails;
	} seq_state_t;

	localparam seq_state_t SEQ_RESET = '{phase: PH_IDLE, address: 8'd0, send_len: 8'd0,
		send_pos: 8'd0, probe: 1'b0, retries: 16'd0, limit: RETRY_RESET, last: RES_IDLE,
		fails: 16'd0};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	item_t       item = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	res_t        res;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = 16'd0;

	// Expected sequencer state and buffer, advanced on each accepted item.
	seq_state_t  seq_exp = SEQ_RESET;
	logic [7:0]  exp_store [BUF_DEPTH];
	// Look-ahead copy used while planning stimulus, and which entries it has loaded.
	seq_state_t  seq_gen = SEQ_RESET;
	bit          gen_loaded [BUF_DEPTH];

	item_t       op_backlog [$];
	res_t        controller_cmds_due [$];

	int          hold_cycles = 0;
	int          sink_wait = 0;
	bit          src_calm = 1'b0;
	bit          sink_calm = 1'b0;
	int          quiet_cycles = 0;
	int          plan_count = 0;
	int          ops_accepted = 0;
	int          cmds_checked = 0;
	int          xfer_ok = 0;
	int          xfer_err = 0;
	int          limit_writes = 0;
	int          fault_count = 0;

	i2c_master_write_sequencer u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// One poll, submit, load or abort applied to the sequencer state; returns its command item.
	function automatic res_t sequencer_step(inout seq_state_t s, input item_t it,
		input logic [7:0] tx_byte);
		res_t r;
		logic failed;
		logic stalled;
		r = '0;
		failed = 1'b0;
		stalled = 1'b0;
		case (it.opcode)
			OP_SUBMIT_WRITE, OP_SUBMIT_PROBE: begin
				if (s.phase == PH_IDLE && (it.opcode == OP_SUBMIT_PROBE ||
					(it.length != 8'd0 && int'(it.length) <= BUF_DEPTH))) begin
					r.accepted = 1'b1;
					r.clear_ack_failure = it.ack_failure;
					s.address = it.target_address;
					s.send_len = (it.opcode == OP_SUBMIT_PROBE) ? 8'd0 : it.length;
					s.send_pos = 8'd0;
					s.probe = (it.opcode == OP_SUBMIT_PROBE);
					s.retries = 16'd0;
					s.last = RES_BUSY;
					s.phase = PH_WAIT_BUSY;
				end
			end
			OP_ABORT: failed = (s.phase != PH_IDLE);
			OP_POLL: begin
				case (s.phase)
					PH_IDLE: ;
					PH_WAIT_BUSY: begin
						// A busy bus only counts against the limit, whatever the ack flag says.
						if (it.bus_busy) begin
							stalled = 1'b1;
						end else begin
							s.retries = 16'd0;
							s.phase = PH_START;
						end
					end
					PH_START: begin
						r.issue_start = 1'b1;
						s.phase = PH_WAIT_SB;
					end
					PH_WAIT_SB: begin
						if (it.start_sent) begin
							s.retries = 16'd0;
							s.phase = PH_ADDR;
						end else begin
							{failed, stalled} = {it.ack_failure, !it.ack_failure};
						end
					end
					PH_ADDR: begin
						r.data_write_valid = 1'b1;
						r.data_out = s.address;
						s.phase = PH_WAIT_ADDR;
					end
					PH_WAIT_ADDR: begin
						if (it.address_done) begin
							s.retries = 16'd0;
							if (s.probe || s.send_len == 8'd0) begin
								r.issue_stop = 1'b1;
								s.phase = PH_FINISH;
							end else begin
								s.phase = PH_TX;
							end
						end else begin
							{failed, stalled} = {it.ack_failure, !it.ack_failure};
						end
					end
					PH_TX: begin
						r.data_write_valid = 1'b1;
						r.data_out = (int'(s.send_pos) < BUF_DEPTH) ? tx_byte : 8'd0;
						s.send_pos = s.send_pos + 8'd1;
						s.phase = PH_WAIT_TXE;
					end
					PH_WAIT_TXE: begin
						if (it.tx_empty) begin
							s.retries = 16'd0;
							s.phase = (s.send_pos < s.send_len) ? PH_TX : PH_STOP;
						end else begin
							{failed, stalled} = {it.ack_failure, !it.ack_failure};
						end
					end
					PH_STOP: s.phase = PH_WAIT_BTF;
					PH_WAIT_BTF: begin
						if (it.transfer_finished) begin
							r.issue_stop = 1'b1;
							s.phase = PH_FINISH;
						end else begin
							{failed, stalled} = {it.ack_failure, !it.ack_failure};
						end
					end
					PH_FINISH: begin
						r.done_res = 1'b1;
						s.last = RES_OK;
						s.phase = PH_IDLE;
					end
					default: failed = 1'b1;
				endcase
			end
			default: ;
		endcase

		// A wait without progress fails once the count would pass the limit.
		if (stalled) begin
			if (s.retries >= s.limit)
				failed = 1'b1;
			else
				s.retries = s.retries + 16'd1;
		end

		// Failure stops the bus, clears a pending ack failure and asks for recovery.
		if (failed) begin
			r.issue_stop = 1'b1;
			r.clear_ack_failure = it.ack_failure;
			r.request_recovery = 1'b1;
			r.done_res = 1'b1;
			s.phase = PH_IDLE;
			s.last = RES_ERR;
			if (s.fails != 16'hFFFF)
				s.fails = s.fails + 16'd1;
		end

		r.result_code = s.last;
		r.is_idle = (s.phase == PH_IDLE);
		r.error_count = s.fails;
		return r;
	endfunction

	function automatic item_t random_item();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[$bits(item_t)-1:0];
	endfunction

	// Spare opcodes, loads and submits that arrive at the wrong moment.
	function automatic item_t noise_item();
		item_t it;
		it = random_item();
		case ($urandom_range(0, 3))
			0: it.opcode = OP_LOAD;
			1: it.opcode = OP_SUBMIT_WRITE;
			2: it.opcode = OP_SUBMIT_PROBE;
			default: it.opcode = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
		endcase
		return it;
	endfunction

	// Poll whose flags mostly let the current wait progress, else stall or fail on ack.
	function automatic item_t poll_item(logic [3:0] ph);
		item_t it;
		int r;
		logic go;
		it = random_item();
		it.opcode = OP_POLL;
		r = $urandom_range(0, 99);
		go = (r < 70);
		it.ack_failure = go ? it.ack_failure : (r >= 94);
		case (ph)
			PH_WAIT_BUSY: it.bus_busy = !go;
			PH_WAIT_SB:   it.start_sent = go;
			PH_WAIT_ADDR: it.address_done = go;
			PH_WAIT_TXE:  it.tx_empty = go;
			PH_WAIT_BTF:  it.transfer_finished = go;
			default: ;
		endcase
		return it;
	endfunction

	function automatic bit prefix_loaded(int n);
		for (int i = 0; i < n; i++)
			if (!gen_loaded[i])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic int draw_gap(inout bit calm);
		if ($urandom_range(0, 39) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 10);
	endfunction

	// Queues one item and tracks the state it leaves behind.
	task automatic push_item(item_t it, bit counted);
		res_t discard;
		// An idle write submit may only send entries loaded since reset.
		if (it.opcode == OP_SUBMIT_WRITE && seq_gen.phase == PH_IDLE && it.length != 8'd0 &&
			int'(it.length) <= BUF_DEPTH && !prefix_loaded(int'(it.length)))
			it.length = it.length[0] ? 8'd0 : 8'($urandom_range(BUF_DEPTH + 1, 255));
		if (it.opcode == OP_LOAD && seq_gen.phase == PH_IDLE)
			gen_loaded[it.byte_index] = 1'b1;
		discard = sequencer_step(seq_gen, it, 8'd0);
		op_backlog.push_back(it);
		if (counted)
			plan_count++;
	endtask

	task automatic direct(logic [2:0] op, logic [7:0] addr, logic [7:0] len,
		logic [6:0] idx, logic [7:0] data, logic [5:0] flags);
		item_t it;
		it.opcode = op;
		it.target_address = addr;
		it.length = len;
		it.byte_index = idx;
		it.data_byte = data;
		{it.bus_busy, it.start_sent, it.address_done, it.tx_empty, it.transfer_finished,
			it.ack_failure} = flags;
		push_item(it, 1'b1);
	endtask

	// One transaction: abort to idle, load (writes only), submit, then mostly polls until it ends.
	task automatic gen_transaction(int force_len);
		item_t it;
		int n;
		int r;
		bit probe;
		if ($urandom_range(0, 3) == 0)
			push_item(noise_item(), 1'b0);
		it = random_item();
		it.opcode = OP_ABORT;
		push_item(it, 1'b0);
		probe = ($urandom_range(0, 3) == 0) && (force_len == 0);
		if (force_len != 0)
			n = force_len;
		else if ($urandom_range(0, 19) == 0)
			n = $urandom_range(9, 40);
		else
			n = $urandom_range(1, 8);
		if (!probe) begin
			for (int i = 0; i < n; i++) begin
				if (!gen_loaded[i] || $urandom_range(0, 1) == 0) begin
					it = random_item();
					it.opcode = OP_LOAD;
					it.byte_index = 7'(i);
					push_item(it, 1'b1);
				end
			end
		end
		it = random_item();
		it.opcode = probe ? OP_SUBMIT_PROBE : OP_SUBMIT_WRITE;
		if (!probe)
			it.length = 8'(n);
		push_item(it, 1'b1);
		while (seq_gen.phase != PH_IDLE) begin
			r = $urandom_range(0, 99);
			if (r < 2) begin
				it = random_item();
				it.opcode = OP_ABORT;
				push_item(it, 1'b1);
			end else if (r < 6) begin
				push_item(noise_item(), 1'b0);
			end else begin
				push_item(poll_item(seq_gen.phase), 1'b1);
			end
		end
	endtask

	task automatic report(string what);
		if (fault_count < REPORT_LINES)
			$display("MISMATCH at %0d ns, result %0d: %s", $time, cmds_checked, what);
		fault_count++;
	endtask

	task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
		if (got !== want)
			report($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	// Waits until every queued item has gone in and every result has come out.
	task automatic wait_drained();
		while (op_backlog.size() != 0 || item_valid || controller_cmds_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_retry_limit(logic [15:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		seq_exp.limit = value;
		seq_gen.limit = value;
		limit_writes++;
		@(negedge clk);
	endtask

	// Item driver: presents queued items and predicts each accepted one.
	always @(posedge clk) begin : drive_items
		res_t want;
		if (!arst_n) begin
			item_valid <= 1'b0;
			hold_cycles <= 0;
		end else begin
			if (item_valid && !item_stall) begin
				if (item.opcode == OP_LOAD && seq_exp.phase == PH_IDLE)
					exp_store[item.byte_index] = item.data_byte;
				want = sequencer_step(seq_exp, item, exp_store[seq_exp.send_pos[BUF_AW-1:0]]);
				controller_cmds_due.push_back(want);
				ops_accepted++;
			end
			if (!item_valid || !item_stall) begin
				if (hold_cycles != 0) begin
					item_valid <= 1'b0;
					hold_cycles <= hold_cycles - 1;
				end else if (op_backlog.size() != 0) begin
					item <= op_backlog.pop_front();
					item_valid <= 1'b1;
					hold_cycles <= draw_gap(src_calm);
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compares each accepted result with the oldest prediction.
	always @(posedge clk) begin : check_cmds
		res_t want;
		int n;
		if (!arst_n) begin
			res_stall <= 1'b0;
			sink_wait <= 0;
		end else if (res_valid && !res_stall) begin
			if (controller_cmds_due.size() == 0) begin
				report("result item with no operation pending");
			end else begin
				want = controller_cmds_due.pop_front();
				check_field("accepted", 16'(res.accepted), 16'(want.accepted));
				check_field("data_write_valid", 16'(res.data_write_valid),
					16'(want.data_write_valid));
				check_field("data_out", 16'(res.data_out), 16'(want.data_out));
				check_field("issue_start", 16'(res.issue_start), 16'(want.issue_start));
				check_field("issue_stop", 16'(res.issue_stop), 16'(want.issue_stop));
				check_field("clear_ack_failure", 16'(res.clear_ack_failure),
					16'(want.clear_ack_failure));
				check_field("request_recovery", 16'(res.request_recovery),
					16'(want.request_recovery));
				check_field("done_res", 16'(res.done_res), 16'(want.done_res));
				check_field("result_code", 16'(res.result_code), 16'(want.result_code));
				check_field("is_idle", 16'(res.is_idle), 16'(want.is_idle));
				check_field("error_count", res.error_count, want.error_count);
				if (want.done_res && want.result_code == RES_OK)
					xfer_ok++;
				if (want.done_res && want.result_code == RES_ERR)
					xfer_err++;
			end
			cmds_checked++;
			n = draw_gap(sink_calm);
			sink_wait <= n;
			res_stall <= (n != 0);
		end else if (sink_wait != 0) begin
			sink_wait <= sink_wait - 1;
			res_stall <= (sink_wait > 1);
		end
	end

	// Watchdog: ends the run when no channel has moved for too long.
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (res_valid && !res_stall) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Timeout: no item moved for %0d cycles.", QUIET_LIMIT);
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Stimulus plan: directed items, then random transactions under several retry limits.
	initial begin
		int limit_plan [6];
		limit_plan = '{400, 1, 65535, 2, 0, 400};
		limit_plan[4] = $urandom_range(3, 12);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Idle no-ops, rejected submits and buffer loads.
		direct(OP_POLL, 8'h00, 8'h00, 7'd0, 8'h00, F_ALL);
		direct(OP_ABORT, 8'hFF, 8'hFF, 7'd127, 8'hFF, F_NONE);
		direct(OP_SPARE_FIRST, 8'h00, 8'h01, 7'd0, 8'h00, F_NONE);
		direct(OP_SUBMIT_WRITE, 8'h50, 8'd0, 7'd0, 8'h00, F_NONE);
		direct(OP_SUBMIT_WRITE, 8'h50, 8'(BUF_DEPTH + 1), 7'd0, 8'h00, F_NONE);
		direct(OP_LOAD, 8'h00, 8'h00, 7'd0, 8'hFF, F_NONE);
		direct(OP_LOAD, 8'h00, 8'h00, 7'd127, 8'h00, F_NONE);
		direct(OP_LOAD, 8'h00, 8'h00, 7'd1, 8'h5A, F_NONE);
		// Probe with a pending ack failure; submit and load while busy are refused.
		direct(OP_SUBMIT_PROBE, 8'hFF, 8'd0, 7'd0, 8'h00, F_ACK);
		direct(OP_SUBMIT_WRITE, 8'h00, 8'd1, 7'd0, 8'h00, F_NONE);
		direct(OP_LOAD, 8'h00, 8'h00, 7'd0, 8'h00, F_NONE);
		direct(OP_POLL, 8'h00, 8'h00, 7'd0, 8'h00, F_BUSY);
		direct(OP_POLL, 8'h00, 8'h00, 7'd0, 8'h00, F_NONE);
		direct(OP_POLL, 8'h00, 8'h00, 7'd0, 8'h00, F_NONE);
		// Start flag and ack failure together: the flag wins.
		direct(OP_POLL, 8'h00, 8'h00, 7'd0, 8'h00, F_SB | F_ACK);
		direct(OP_POLL, 8'h00, 8'h00, 7'd0, 8'h00, F_NONE);
		direct(OP_POLL, 8'h00, 8'h00, 7'd0, 8'h00, F_ADDR);
		direct(OP_POLL, 8'h00, 8'h00, 7'd0, 8'h00, F_NONE);
		// Two-byte write that fails on an ack failure after the first byte.
		direct(OP_SUBMIT_WRITE, 8'hA0, 8'd2, 7'd0, 8'h00, F_NONE);
		direct(OP_POLL, 8'h00, 8'h00, 7'd0, 8'h00, F_NONE);
		direct(OP_POLL, 8'h00, 8'h00, 7'd0, 8'h00, F_NONE);
		direct(OP_POLL, 8'h00, 8'h00, 7'd0, 8'h00, F_SB);
		direct(OP_POLL, 8'h00, 8'h00, 7'd0, 8'h00, F_NONE);
		direct(OP_POLL, 8'h00, 8'h00, 7'd0, 8'h00, F_ADDR);
		direct(OP_POLL, 8'h00, 8'h00, 7'd0, 8'h00, F_NONE);
		direct(OP_POLL, 8'h00, 8'h00, 7'd0, 8'h00, F_ACK);

		for (int k = 0; k < 6; k++) begin
			if (k != 0) begin
				wait_drained();
				set_retry_limit(16'(limit_plan[k]));
			end
			plan_count = 0;
			while (plan_count < ITEMS_PER_SETTING)
				gen_transaction((k == 2 && plan_count == 0) ? BUF_DEPTH : 0);
		end

		wait_drained();
		repeat (10) @(negedge clk);
		if (controller_cmds_due.size() != 0)
			report($sformatf("%0d predicted results never arrived",
				controller_cmds_due.size()));
		$display("Checked %0d result items for %0d operations: %0d transfers completed,",
			cmds_checked, ops_accepted, xfer_ok);
		$display("%0d ended in error, over %0d retry limit writes from 1 up to 65535.",
			xfer_err, limit_writes);
		if (fault_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
